FILE: hw/rtl/pst_pkg.sv
// Shared types and constants for the process slot table.
package pst_pkg;

  localparam int SLOT_BITS    = 4;
  localparam int NUM_SLOTS    = 1 << SLOT_BITS;
  localparam int MAX_GEN_BITS = 16;
  localparam int HANDLE_W     = MAX_GEN_BITS + SLOT_BITS;
  localparam int LIVE_W       = SLOT_BITS + 1;
  localparam int GEN_CFG_W    = 5;
  localparam int DUR_W        = 32;
  localparam int ELAPSED_W    = 31;

  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_RELEASE = 3'd1;
  localparam logic [2:0] OP_SLEEP   = 3'd2;
  localparam logic [2:0] OP_WAIT    = 3'd3;
  localparam logic [2:0] OP_MESSAGE = 3'd4;
  localparam logic [2:0] OP_TICK    = 3'd5;

  localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_WOKEN     = 2'd2;
  localparam logic [1:0] STATUS_DONE      = 2'd3;

  localparam logic REG_GEN_BITS = 1'b0;

  typedef enum logic [2:0] {
    CMD_ALLOC,
    CMD_RELEASE,
    CMD_SLEEP,
    CMD_WAIT,
    CMD_MESSAGE,
    CMD_TICK,
    CMD_NONE
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ALLOC,
    BK_SLOT_OP,
    BK_TICK,
    BK_TICK_END
  } back_state_t;

  typedef struct packed {
    cmd_t                        cmd;
    logic [SLOT_BITS-1:0]        slot;
    logic signed [DUR_W-1:0]     duration;
    logic [ELAPSED_W-1:0]        elapsed;
  } item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [HANDLE_W-1:0]  handle;
    logic [SLOT_BITS-1:0] woken_slot;
    logic [LIVE_W-1:0]    live_count;
    logic                 last;
  } result_t;

endpackage

FILE: hw/rtl/pst_front.sv
// Front end: accepts requests, decodes the operation and queues them for the back end.
module pst_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                request_valid,
  output logic                                request_stall,
  input  logic [2:0]                          operation,
  input  logic [pst_pkg::SLOT_BITS-1:0]       slot,
  input  logic signed [pst_pkg::DUR_W-1:0]    duration,
  input  logic [pst_pkg::ELAPSED_W-1:0]       elapsed,
  output logic                                item_valid,
  output pst_pkg::item_t                      item,
  input  logic                                item_pop
);

  pst_pkg::item_t queue [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  pst_pkg::cmd_t  cmd;
  logic           push;

  always_comb begin
    unique case (operation)
      pst_pkg::OP_ALLOC:   cmd = pst_pkg::CMD_ALLOC;
      pst_pkg::OP_RELEASE: cmd = pst_pkg::CMD_RELEASE;
      pst_pkg::OP_SLEEP:   cmd = pst_pkg::CMD_SLEEP;
      pst_pkg::OP_WAIT:    cmd = pst_pkg::CMD_WAIT;
      pst_pkg::OP_MESSAGE: cmd = pst_pkg::CMD_MESSAGE;
      pst_pkg::OP_TICK:    cmd = pst_pkg::CMD_TICK;
      default:             cmd = pst_pkg::CMD_NONE;
    endcase
  end

  assign request_stall = (count == 2'd2);
  assign push          = request_valid && !request_stall;
  assign item_valid    = (count != 2'd0);
  assign item          = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        queue[wr_ptr] <= '{cmd: cmd, slot: slot, duration: duration, elapsed: elapsed};
        wr_ptr        <= ~wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, item_pop};
    end
  end

endmodule

FILE: hw/rtl/pst_back.sv
// Back end: slot table, allocation scan, timer sweep and the result register.
module pst_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [pst_pkg::GEN_CFG_W-1:0]         generation_bits,
  input  logic                                  item_valid,
  input  pst_pkg::item_t                        item,
  output logic                                  item_pop,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output pst_pkg::result_t                      result
);

  localparam logic [pst_pkg::SLOT_BITS-1:0] LAST_SLOT =
    pst_pkg::SLOT_BITS'(pst_pkg::NUM_SLOTS - 1);

  pst_pkg::back_state_t state;
  pst_pkg::back_state_t state_next;

  logic                               dead      [pst_pkg::NUM_SLOTS];
  logic [pst_pkg::MAX_GEN_BITS-1:0]   gen       [pst_pkg::NUM_SLOTS];
  logic                               waiting   [pst_pkg::NUM_SLOTS];
  logic signed [pst_pkg::DUR_W-1:0]   remaining [pst_pkg::NUM_SLOTS];
  logic                               on_msg    [pst_pkg::NUM_SLOTS];

  pst_pkg::item_t                     cur;
  logic [pst_pkg::SLOT_BITS-1:0]      idx;
  logic [pst_pkg::SLOT_BITS-1:0]      visited;
  logic [pst_pkg::SLOT_BITS-1:0]      scan_start;
  logic [pst_pkg::LIVE_W-1:0]         live;
  logic                               pend_v;
  logic [pst_pkg::SLOT_BITS-1:0]      pend_slot;

  logic                               out_free;
  logic                               emit;
  pst_pkg::result_t                   res;
  logic                               tick_step;
  logic                               expire;
  logic signed [pst_pkg::DUR_W:0]     diff;
  logic [pst_pkg::MAX_GEN_BITS-1:0]   gmask;
  logic [pst_pkg::MAX_GEN_BITS-1:0]   gen_new;
  logic                               cur_dead;
  logic                               cur_parked;

  function automatic logic [pst_pkg::MAX_GEN_BITS-1:0] gen_mask(
    input logic [pst_pkg::GEN_CFG_W-1:0] bits
  );
    logic [pst_pkg::GEN_CFG_W-1:0]    b;
    logic [pst_pkg::MAX_GEN_BITS-1:0] m;
    b = bits;
    if (b == '0) b = pst_pkg::GEN_CFG_W'(1);
    if (b > pst_pkg::GEN_CFG_W'(pst_pkg::MAX_GEN_BITS)) begin
      b = pst_pkg::GEN_CFG_W'(pst_pkg::MAX_GEN_BITS);
    end
    for (int k = 0; k < pst_pkg::MAX_GEN_BITS; k++) begin
      m[k] = (pst_pkg::GEN_CFG_W'(k) < b);
    end
    return m;
  endfunction

  assign out_free   = !result_valid || !result_stall;
  assign cur_dead   = dead[idx];
  assign cur_parked = waiting[idx] && !remaining[idx][pst_pkg::DUR_W-1];
  assign diff       = {remaining[idx][pst_pkg::DUR_W-1], remaining[idx]}
                    - {2'b00, cur.elapsed};
  assign expire     = cur_parked && (diff[pst_pkg::DUR_W] || diff == '0);
  assign gmask      = gen_mask(generation_bits);
  assign gen_new    = ((gen[idx] & gmask) + 1'b1) & gmask;
  assign tick_step  = (state == pst_pkg::BK_TICK) && !(expire && pend_v && !out_free);

  always_comb begin
    state_next = state;
    unique case (state)
      pst_pkg::BK_IDLE: begin
        if (item_valid) begin
          if (item.cmd == pst_pkg::CMD_ALLOC) begin
            state_next = pst_pkg::BK_ALLOC;
          end else if (item.cmd == pst_pkg::CMD_TICK) begin
            state_next = pst_pkg::BK_TICK;
          end else begin
            state_next = pst_pkg::BK_SLOT_OP;
          end
        end
      end
      pst_pkg::BK_ALLOC: begin
        if (out_free && (cur_dead || visited == LAST_SLOT)) state_next = pst_pkg::BK_IDLE;
      end
      pst_pkg::BK_SLOT_OP: begin
        if (out_free) state_next = pst_pkg::BK_IDLE;
      end
      pst_pkg::BK_TICK: begin
        if (tick_step && idx == LAST_SLOT) state_next = pst_pkg::BK_TICK_END;
      end
      pst_pkg::BK_TICK_END: begin
        if (out_free) state_next = pst_pkg::BK_IDLE;
      end
      default: state_next = pst_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    item_pop = 1'b0;
    emit     = 1'b0;
    res      = '{status: pst_pkg::STATUS_DONE, handle: '0, woken_slot: '0,
                 live_count: live, last: 1'b1};
    unique case (state)
      pst_pkg::BK_IDLE: begin
        item_pop = item_valid;
      end
      pst_pkg::BK_ALLOC: begin
        if (out_free && cur_dead) begin
          emit           = 1'b1;
          res.status     = pst_pkg::STATUS_ALLOCATED;
          res.handle     = {gen_new, idx};
          res.woken_slot = idx;
          res.live_count = live + 1'b1;
        end else if (out_free && visited == LAST_SLOT) begin
          emit       = 1'b1;
          res.status = pst_pkg::STATUS_FULL;
        end
      end
      pst_pkg::BK_SLOT_OP: begin
        emit = out_free;
        if (cur.cmd == pst_pkg::CMD_RELEASE && !cur_dead) begin
          res.live_count = live - 1'b1;
        end
        if (cur.cmd == pst_pkg::CMD_MESSAGE && !cur_dead && waiting[idx] && on_msg[idx]) begin
          res.status     = pst_pkg::STATUS_WOKEN;
          res.woken_slot = idx;
        end
      end
      pst_pkg::BK_TICK: begin
        if (tick_step && expire && pend_v) begin
          emit           = 1'b1;
          res.status     = pst_pkg::STATUS_WOKEN;
          res.woken_slot = pend_slot;
          res.last       = 1'b0;
        end
      end
      pst_pkg::BK_TICK_END: begin
        emit = out_free;
        if (pend_v) begin
          res.status     = pst_pkg::STATUS_WOKEN;
          res.woken_slot = pend_slot;
        end
      end
      default: begin
        item_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pst_pkg::BK_IDLE;
      scan_start   <= '0;
      live         <= '0;
      result_valid <= 1'b0;
      pend_v       <= 1'b0;
      for (int s = 0; s < pst_pkg::NUM_SLOTS; s++) begin
        dead[s]      <= 1'b1;
        gen[s]       <= '0;
        waiting[s]   <= 1'b0;
        remaining[s] <= '0;
        on_msg[s]    <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (emit) begin
        result_valid <= 1'b1;
        result       <= res;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (item_pop) begin
        cur     <= item;
        visited <= '0;
        pend_v  <= 1'b0;
        if (item.cmd == pst_pkg::CMD_ALLOC) begin
          idx <= scan_start;
        end else if (item.cmd == pst_pkg::CMD_TICK) begin
          idx <= '0;
        end else begin
          idx <= item.slot;
        end
      end
      case (state)
        pst_pkg::BK_ALLOC: begin
          if (cur_dead) begin
            if (out_free) begin
              gen[idx]       <= gen_new;
              dead[idx]      <= 1'b0;
              waiting[idx]   <= 1'b0;
              remaining[idx] <= '0;
              on_msg[idx]    <= 1'b0;
              live           <= live + 1'b1;
              scan_start     <= idx + 1'b1;
            end
          end else if (visited != LAST_SLOT) begin
            idx     <= idx + 1'b1;
            visited <= visited + 1'b1;
          end
        end
        pst_pkg::BK_SLOT_OP: begin
          if (out_free && !cur_dead) begin
            case (cur.cmd)
              pst_pkg::CMD_RELEASE: begin
                dead[idx]      <= 1'b1;
                waiting[idx]   <= 1'b0;
                remaining[idx] <= '0;
                on_msg[idx]    <= 1'b0;
                live           <= live - 1'b1;
              end
              pst_pkg::CMD_SLEEP, pst_pkg::CMD_WAIT: begin
                waiting[idx]   <= 1'b1;
                remaining[idx] <= cur.duration;
                on_msg[idx]    <= (cur.cmd == pst_pkg::CMD_WAIT);
              end
              pst_pkg::CMD_MESSAGE: begin
                if (waiting[idx] && on_msg[idx]) begin
                  waiting[idx]   <= 1'b0;
                  remaining[idx] <= '0;
                  on_msg[idx]    <= 1'b0;
                end
              end
              default: begin
                pend_v <= 1'b0;
              end
            endcase
          end
        end
        pst_pkg::BK_TICK: begin
          if (tick_step) begin
            if (expire) begin
              waiting[idx]   <= 1'b0;
              remaining[idx] <= '0;
              on_msg[idx]    <= 1'b0;
              pend_v         <= 1'b1;
              pend_slot      <= idx;
            end else if (cur_parked) begin
              remaining[idx] <= diff[pst_pkg::DUR_W-1:0];
            end
            idx <= idx + 1'b1;
          end
        end
        pst_pkg::BK_TICK_END: begin
          if (out_free) pend_v <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/process_slot_table_with_wait_timers.sv
// Top level of the process slot table with wait timers.
// Requests enter a two-deep queue and are carried out one at a time by the back end, which
// owns the sixteen-slot table and a one-result output register. Release, sleep, wait,
// message and unused codes are popped in the idle state and answered from the slot-op state.
// Alloc walks the slots round-robin from the scan pointer, one slot per cycle. Tick sweeps
// all sixteen slots, one per cycle; each woken slot gives one result, the last one marked,
// and a sweep that wakes none gives a single done result. A stalled result holds the sweep
// only when a second wake is found while the previous one is still waiting to be delivered.
module process_slot_table_with_wait_timers (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                request_valid,
  output logic                                request_stall,
  input  logic [2:0]                          operation,
  input  logic [pst_pkg::SLOT_BITS-1:0]       slot,
  input  logic signed [pst_pkg::DUR_W-1:0]    duration,
  input  logic [pst_pkg::ELAPSED_W-1:0]       elapsed,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [1:0]                          status,
  output logic [pst_pkg::HANDLE_W-1:0]        handle,
  output logic [pst_pkg::SLOT_BITS-1:0]       woken_slot,
  output logic [pst_pkg::LIVE_W-1:0]          live_count,
  output logic                                last
);

  logic [pst_pkg::GEN_CFG_W-1:0] generation_bits;
  logic                          item_valid;
  logic                          item_pop;
  pst_pkg::item_t                item;
  pst_pkg::result_t              result;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == pst_pkg::REG_GEN_BITS)
                ? {{(32 - pst_pkg::GEN_CFG_W){1'b0}}, generation_bits} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      generation_bits <= pst_pkg::GEN_CFG_W'(8);
    end else if (psel && penable && pwrite && pready && paddr[2] == pst_pkg::REG_GEN_BITS) begin
      generation_bits <= pwdata[pst_pkg::GEN_CFG_W-1:0];
    end
  end

  pst_front u_front (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .operation     (operation),
    .slot          (slot),
    .duration      (duration),
    .elapsed       (elapsed),
    .item_valid    (item_valid),
    .item          (item),
    .item_pop      (item_pop)
  );

  pst_back u_back (
    .clk             (clk),
    .rst             (rst),
    .generation_bits (generation_bits),
    .item_valid      (item_valid),
    .item            (item),
    .item_pop        (item_pop),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result          (result)
  );

  assign status     = result.status;
  assign handle     = result.handle;
  assign woken_slot = result.woken_slot;
  assign live_count = result.live_count;
  assign last       = result.last;

endmodule

FILE: hw/rtl/pst_checker.sv
// Port-level checks for the process slot table, bound to the top level.
module pst_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic [1:0]                    status,
  input logic [pst_pkg::HANDLE_W-1:0]  handle,
  input logic [pst_pkg::SLOT_BITS-1:0] woken_slot,
  input logic [pst_pkg::LIVE_W-1:0]    live_count,
  input logic                          last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status) && $stable(handle)
      && $stable(woken_slot) && $stable(live_count) && $stable(last))
    else $error("Stalled result changed.");

  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != pst_pkg::STATUS_ALLOCATED |-> handle == '0)
    else $error("Handle set on a result that is not an allocation.");

  a_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == pst_pkg::STATUS_FULL || status == pst_pkg::STATUS_DONE)
      |-> last && woken_slot == '0)
    else $error("Full or done result is not a single final result.");

  a_alloc: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == pst_pkg::STATUS_ALLOCATED
      |-> handle[pst_pkg::SLOT_BITS-1:0] == woken_slot && last && live_count != '0)
    else $error("Allocation result is inconsistent.");

  a_live: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> live_count <= pst_pkg::LIVE_W'(pst_pkg::NUM_SLOTS))
    else $error("Live count exceeds the number of slots.");

endmodule

bind process_slot_table_with_wait_timers pst_checker u_pst_checker (.*);
